// ----- rtl/gwts_pkg.sv -----
package gwts_pkg;

  localparam int SIZE_W = 11;
  localparam int PIX_W  = 8;
  localparam int CFG_AW = 2;
  localparam int DIV_W  = 4;

  localparam logic [CFG_AW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic OP_GATHER   = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;
  localparam logic [DIV_W-1:0] DIV_FIRST  = 4'd8;

  typedef struct packed {
    logic gather_accept;
    logic gather_step;
    logic sweep_step;
    logic div_init;
    logic div_step;
    logic commit;
    logic classify;
  } cmd_t;

  typedef struct packed {
    logic last_pixel;
    logic sweep_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/gradient_weighted_threshold_segment.sv -----
// Classify beat: result registered after accept; 1 beat per cycle if sink keeps up.
// Gather beat: row buffer read on accept, then accumulate and write back.
// Last gather beat: accumulate, then sweep the bottom row (read, then accumulate, per
// column), then restoring division, then the report beat is registered.
// Reset (rst, synchronous): width and height 512, threshold 0, flag 0, sums cleared.
module gradient_weighted_threshold_segment
  import gwts_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [SIZE_W-1:0] cfg_wdata,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,  // pixel[7:0]
  input  logic              s_tuser,  // op
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,  // foreground, threshold[8:1], no_gradient, zero pad
  output logic              m_tuser   // is_threshold_report
);

  cmd_t cmd;
  sts_t sts;

  gwts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_op     (s_tuser),
    .sts      (sts),
    .cmd      (cmd),
    .s_tready (s_tready)
  );

  gwts_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .pixel     (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// ----- rtl/gwts_ram.sv -----
module gwts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/gwts_ctrl.sv -----
module gwts_ctrl
  import gwts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_op,
  input  sts_t sts,
  output cmd_t cmd,
  output logic s_tready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GACC = 3'd1;
  localparam logic [2:0] S_SRD  = 3'd2;
  localparam logic [2:0] S_SACC = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_RPT  = 3'd5;

  logic [2:0] state, state_next;

  assign s_tready = (state == S_IDLE) && sts.out_free;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && sts.out_free) begin
          if (s_op == OP_CLASSIFY) begin
            cmd.classify = 1'b1;
          end else begin
            cmd.gather_accept = 1'b1;
            state_next        = S_GACC;
          end
        end
      end
      S_GACC: begin
        cmd.gather_step = 1'b1;
        state_next      = sts.last_pixel ? S_SRD : S_IDLE;
      end
      S_SRD: state_next = S_SACC;
      S_SACC: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end else begin
          state_next = S_SRD;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_RPT;
      end
      S_RPT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/gwts_dp.sv -----
module gwts_dp
  import gwts_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [SIZE_W-1:0] cfg_wdata,
  input  logic [PIX_W-1:0]  pixel,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,
  output logic              m_tuser
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RAW = $clog2(MAX_HEIGHT);
  localparam int RCW = $clog2(MAX_HEIGHT + 1);
  localparam int GSW = PIX_W + AW + RAW;
  localparam int WSW = GSW + PIX_W;

  logic [SIZE_W-1:0] image_width, image_height;
  logic [CW-1:0]     w_eff;
  logic [RCW-1:0]    h_eff;

  logic [AW-1:0]     col;
  logic [RAW-1:0]    row;
  logic [CW-1:0]     col_inc;
  logic [RCW-1:0]    row_inc;
  logic              col_last, row_last;

  logic [PIX_W-1:0]  pix_hold;
  logic [PIX_W-1:0]  left_hold;
  logic [GSW-1:0]    gsum;
  logic [WSW-1:0]    wsum;
  logic [PIX_W-1:0]  threshold;
  logic              no_gradient;

  logic [PIX_W-1:0]  prev_c, prev_r, older_c;
  logic [AW-1:0]     col_nx;

  logic [PIX_W-1:0]  ctr, left, right, up, down;
  logic [PIX_W:0]    ah, av;
  logic [PIX_W-1:0]  mag;
  logic [2*PIX_W-1:0] prod;
  logic              acc_en;

  logic [WSW-1:0]    rem, dvs;
  logic [DIV_W-1:0]  div_cnt;
  logic [PIX_W-1:0]  quo;
  logic              sat;
  logic              fits;

  logic              out_valid, out_fg, out_ng, out_rpt;
  logic [PIX_W-1:0]  out_thr;

  always_comb begin
    if (image_width == '0) w_eff = CW'(1);
    else if (32'(image_width) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(image_width);
    if (image_height == '0) h_eff = RCW'(1);
    else if (32'(image_height) > MAX_HEIGHT) h_eff = RCW'(MAX_HEIGHT);
    else h_eff = RCW'(image_height);
  end

  assign col_inc  = CW'(col) + CW'(1);
  assign row_inc  = RCW'(row) + RCW'(1);
  assign col_last = col_inc >= w_eff;
  assign row_last = row_inc >= h_eff;
  assign col_nx   = col + AW'(1);

  gwts_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev (
    .clk     (clk),
    .we      (cmd.gather_step),
    .waddr   (col),
    .wdata   (pix_hold),
    .raddr_a (col),
    .raddr_b (col_nx),
    .rdata_a (prev_c),
    .rdata_b (prev_r)
  );

  gwts_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk     (clk),
    .we      (cmd.gather_step && (row != '0)),
    .waddr   (col),
    .wdata   (prev_c),
    .raddr_a (col),
    .raddr_b (col),
    .rdata_a (older_c),
    .rdata_b ()
  );

  // gradient of the centre pixel; bottom row replicates downward
  always_comb begin
    ctr   = prev_c;
    left  = (col == '0) ? ctr : left_hold;
    right = col_last ? ctr : prev_r;
    if (cmd.sweep_step) begin
      up   = (h_eff == RCW'(1)) ? ctr : older_c;
      down = ctr;
    end else begin
      up   = (row == RAW'(1)) ? ctr : older_c;
      down = pix_hold;
    end
    ah   = (right >= left) ? {1'b0, right - left} : {1'b0, left - right};
    av   = (up >= down) ? {1'b0, up - down} : {1'b0, down - up};
    mag  = (ah >= av) ? ah[PIX_W-1:0] : av[PIX_W-1:0];
    prod = ctr * mag;
  end

  assign acc_en = cmd.sweep_step || (cmd.gather_step && (row != '0));
  assign fits   = rem >= dvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_W'(512);
      image_height <= SIZE_W'(512);
      col          <= '0;
      row          <= '0;
      gsum         <= '0;
      wsum         <= '0;
      left_hold    <= '0;
      threshold    <= '0;
      no_gradient  <= 1'b0;
      div_cnt      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (m_tready) out_valid <= 1'b0;
      if (cfg_wen && (cfg_addr == CFG_IMAGE_WIDTH || cfg_addr == CFG_IMAGE_HEIGHT)) begin
        if (cfg_addr == CFG_IMAGE_WIDTH) image_width <= cfg_wdata;
        else image_height <= cfg_wdata;
        col       <= '0;
        row       <= '0;
        gsum      <= '0;
        wsum      <= '0;
        left_hold <= '0;
      end
      if (acc_en) begin
        gsum      <= gsum + GSW'(mag);
        wsum      <= wsum + WSW'(prod);
        left_hold <= ctr;
      end
      if (cmd.gather_step) begin
        if (col_last) begin
          col <= '0;
          if (!row_last) row <= row + RAW'(1);
        end else begin
          col <= col + AW'(1);
        end
      end
      if (cmd.sweep_step && !col_last) col <= col + AW'(1);
      if (cmd.div_init) div_cnt <= DIV_FIRST;
      if (cmd.div_step && div_cnt != '0) div_cnt <= div_cnt - DIV_W'(1);
      if (cmd.commit) begin
        if (gsum == '0) begin
          threshold   <= '0;
          no_gradient <= 1'b1;
          out_thr     <= '0;
          out_ng      <= 1'b1;
        end else begin
          threshold   <= sat ? FULL_SCALE : quo;
          no_gradient <= 1'b0;
          out_thr     <= sat ? FULL_SCALE : quo;
          out_ng      <= 1'b0;
        end
        out_valid <= 1'b1;
        out_fg    <= 1'b0;
        out_rpt   <= 1'b1;
        col       <= '0;
        row       <= '0;
        gsum      <= '0;
        wsum      <= '0;
        left_hold <= '0;
      end
      if (cmd.classify) begin
        out_valid <= 1'b1;
        out_fg    <= pixel >= threshold;
        out_thr   <= threshold;
        out_ng    <= no_gradient;
        out_rpt   <= 1'b0;
      end
    end
  end

  // div_init comes with the last sweep step, so its sums include that step
  always_ff @(posedge clk) begin
    if (cmd.gather_accept) pix_hold <= pixel;
    if (cmd.div_init) begin
      rem <= wsum + WSW'(prod);
      dvs <= {gsum + GSW'(mag), {PIX_W{1'b0}}};
      quo <= '0;
      sat <= 1'b0;
    end else if (cmd.div_step) begin
      if (fits) rem <= rem - dvs;
      dvs <= dvs >> 1;
      if (div_cnt == DIV_FIRST) sat <= fits;
      else quo <= {quo[PIX_W-2:0], fits};
    end
  end

  assign sts.last_pixel = col_last && row_last;
  assign sts.sweep_last = col_last;
  assign sts.div_last   = div_cnt == '0;
  assign sts.out_free   = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_ng, out_thr, out_fg};
  assign m_tuser  = out_rpt;

  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(cmd.commit && cmd.classify))
    else $error("two results loaded at once");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    no_gradient |-> (threshold == '0))
    else $error("no_gradient with nonzero threshold");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    CW'(col) < w_eff)
    else $error("column beyond image width");

  a_div_range: assert property (@(posedge clk) disable iff (rst)
    div_cnt <= DIV_FIRST)
    else $error("divider step count out of range");

endmodule
